### sv/tsp_pkg.sv
// Shared types, codes and helpers for the trapezoid step profile generator.
// No dependencies; used by every module of the block except tsp_div.
package tsp_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_PLAN = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_POWER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_POWER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_OFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_USTEP_MODE   = 3'd5;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [15:0] RST_FRAME_PERIOD = 16'd13333;
    localparam logic [6:0]  RST_RUN_POWER    = 7'd100;
    localparam logic [6:0]  RST_STOP_POWER   = 7'd60;

    // Stop sequence phases
    localparam logic [1:0] PH_ARMED   = 2'd0;
    localparam logic [1:0] PH_STOPPED = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    // Input word layout (tdata), lowest bit first
    localparam int unsigned IN_TDATA_W   = 168;
    localparam int unsigned IN_TARGET_LO = 0;
    localparam int unsigned IN_ACCEND_LO = 32;
    localparam int unsigned IN_DECST_LO  = 64;
    localparam int unsigned IN_CRUISE_LO = 96;
    localparam int unsigned IN_AINC_LO   = 104;
    localparam int unsigned IN_DDEC_LO   = 113;
    localparam int unsigned IN_FREM_LO   = 121;
    localparam int unsigned IN_FWD_BIT   = 130;
    localparam int unsigned IN_NEWPOS_LO = 131;
    localparam int unsigned IN_TUSER_W   = 2;

    // Output word layout (tdata), lowest bit first
    localparam int unsigned OUT_TDATA_W = 88;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_DIVGO,
        S_DIV,
        S_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic compare;
        logic exec;
        logic div_start;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_sts;

    // Peak pulse byte: 64*percent/100, percent clamped to 100.
    // 2622/4096 approximates 0.64 closely enough to floor exactly up to 100.
    function automatic logic [7:0] pulse_byte(input logic [6:0] per);
        logic [6:0]  pc;
        logic [18:0] prod;
        pc   = (per > 7'd100) ? 7'd100 : per;
        prod = 19'(pc) * 19'd2622;
        return {1'b0, prod[18:12]};
    endfunction

endpackage

### sv/trapezoid_step_profile_tick.sv
// Top level of the trapezoid step profile generator for one stepper motor.
// Depends on tsp_pkg; instantiates tsp_ctrl and tsp_dp (which holds tsp_div).
//
//  channel  | direction | signals                         | content
//  ---------+-----------+---------------------------------+-------------------------------
//  s_axis   | in        | tvalid tready tdata[167:0] tuser| plan / set / frame tick word
//  m_axis   | out       | tvalid tready tdata[87:0]       | driver update word per item
//  cfg      | in        | i_cfg_we i_cfg_idx i_cfg_data   | register write, no read-back
//
// One item at a time: after accept the controller passes the compare, execute and divide-start
// states to the output state and back to idle before the next word is taken; when a step period
// is computed it also waits for the bit-serial divider to finish.
// A result waits in the output register while the next word is accepted.
// Reset is synchronous, active low; control, profile and config registers return to defaults.
// A stalled m_axis holds the finished word; the item after it waits before delivery.
module trapezoid_step_profile_tick (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // fields low to high: target_position[31:0], accel_end_position[63:32],
    // decel_start_position[95:64], cruise_speed[103:96], accel_increment[112:104],
    // decel_decrement[120:113], final_remainder[129:121], move_forward[130],
    // new_position[162:131], zero fill[167:163]
    input  logic [tsp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // fields: operation[1:0]
    input  logic [tsp_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // fields low to high: run_update[0], run_word[16:1], steps_interval[32:17],
    // power_update[33], pulse_word[49:34], stop_request[50], moving[51],
    // position_now[83:52], zero fill[87:84]
    output logic [tsp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               i_cfg_we,
    input  logic [tsp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tsp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tsp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    tsp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_user   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

### sv/tsp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Used by tsp_dp for the step period; no package dependency.
module tsp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [7:0]  i_divisor,
    output logic [15:0] o_quotient,
    output logic        o_done
);

    logic [15:0] r_quo;
    logic [7:0]  r_rem;
    logic [7:0]  r_dvs;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [8:0]  w_trial;
    logic [8:0]  w_diff;
    logic        w_ge;

    // shift in next dividend bit and try the subtract
    assign w_trial = {r_rem, r_quo[15]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // payload: quotient shifts in from the right as dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[14:0], w_ge};
            r_rem <= w_ge ? w_diff[7:0] : w_trial[7:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

### sv/tsp_ctrl.sv
// Sequencing state machine: accept, compare, execute, divide, deliver.
// Depends on tsp_pkg for the state type and command/status structs.
module tsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output tsp_pkg::t_cmd o_cmd,
    input  tsp_pkg::t_sts i_sts
);
    import tsp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DIVGO;
            end
            S_DIVGO: begin
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/tsp_dp.sv
// Datapath: configuration, profile state, tick arithmetic and output register.
// Depends on tsp_pkg and instantiates tsp_div for the step period.
module tsp_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tsp_pkg::t_cmd                       i_cmd,
    output tsp_pkg::t_sts                       o_sts,
    input  logic                                i_cfg_we,
    input  logic [tsp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tsp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [tsp_pkg::IN_TUSER_W-1:0]      i_in_user,
    input  logic [tsp_pkg::IN_TDATA_W-1:0]      i_in_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [tsp_pkg::OUT_TDATA_W-1:0]     o_out_data
);
    import tsp_pkg::*;

    // configuration registers
    logic [15:0] r_frame;
    logic [6:0]  r_run_pwr;
    logic [6:0]  r_stop_pwr;
    logic        r_cut_off;
    logic        r_reverse;
    logic [1:0]  r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame    <= RST_FRAME_PERIOD;
            r_run_pwr  <= RST_RUN_POWER;
            r_stop_pwr <= RST_STOP_POWER;
            r_cut_off  <= 1'b0;
            r_reverse  <= 1'b0;
            r_mode     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_PERIOD: r_frame    <= i_cfg_data[15:0];
                REG_RUN_POWER:    r_run_pwr  <= i_cfg_data[6:0];
                REG_STOP_POWER:   r_stop_pwr <= i_cfg_data[6:0];
                REG_CUT_OFF:      r_cut_off  <= i_cfg_data[0];
                REG_REVERSE:      r_reverse  <= i_cfg_data[0];
                REG_USTEP_MODE:   r_mode     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // captured input word
    logic [1:0]  r_op;
    logic [31:0] r_in_target;
    logic [31:0] r_in_accend;
    logic [31:0] r_in_decst;
    logic [7:0]  r_in_cruise;
    logic [8:0]  r_in_ainc;
    logic [7:0]  r_in_ddec;
    logic [8:0]  r_in_frem;
    logic        r_in_fwd;
    logic [31:0] r_in_newpos;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_in_user;
            r_in_target <= i_in_data[IN_TARGET_LO +: 32];
            r_in_accend <= i_in_data[IN_ACCEND_LO +: 32];
            r_in_decst  <= i_in_data[IN_DECST_LO +: 32];
            r_in_cruise <= i_in_data[IN_CRUISE_LO +: 8];
            r_in_ainc   <= i_in_data[IN_AINC_LO +: 9];
            r_in_ddec   <= i_in_data[IN_DDEC_LO +: 8];
            r_in_frem   <= i_in_data[IN_FREM_LO +: 9];
            r_in_fwd    <= i_in_data[IN_FWD_BIT];
            r_in_newpos <= i_in_data[IN_NEWPOS_LO +: 32];
        end
    end

    // profile state (speed always stays within 0..255)
    logic [31:0] r_cur;
    logic [31:0] r_goal;
    logic [31:0] r_acc_end;
    logic [31:0] r_dec_start;
    logic [7:0]  r_speed;
    logic [7:0]  r_goal_spd;
    logic [8:0]  r_acc_step;
    logic [7:0]  r_dec_step;
    logic [8:0]  r_rem;
    logic        r_fwd;
    logic [1:0]  r_phase;
    logic        r_enable;
    logic [7:0]  r_steps;
    logic [15:0] r_period;
    logic        r_need_div;

    // per item flags
    logic        r_run;
    logic        r_pw;
    logic [7:0]  r_pbyte;
    logic        r_stopreq;

    // compare stage: distances in direction of travel
    logic [32:0] w_cur33;
    logic [32:0] w_d_acc;
    logic [32:0] w_d_dec;
    logic [32:0] w_d_goal;
    logic        r_at_goal;
    logic        r_a_acc;
    logic        r_a_dec;
    logic        r_a_goal;
    logic        r_left_hi;
    logic [7:0]  r_left_lo;

    assign w_cur33  = {r_cur[31], r_cur};
    assign w_d_acc  = r_fwd ? ({r_acc_end[31], r_acc_end} - w_cur33)
                            : (w_cur33 - {r_acc_end[31], r_acc_end});
    assign w_d_dec  = r_fwd ? ({r_dec_start[31], r_dec_start} - w_cur33)
                            : (w_cur33 - {r_dec_start[31], r_dec_start});
    assign w_d_goal = r_fwd ? ({r_goal[31], r_goal} - w_cur33)
                            : (w_cur33 - {r_goal[31], r_goal});

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_at_goal <= (r_cur == r_goal);
            r_a_acc   <= !w_d_acc[32] && (w_d_acc != '0);
            r_a_dec   <= !w_d_dec[32] && (w_d_dec != '0);
            r_a_goal  <= !w_d_goal[32] && (w_d_goal != '0);
            r_left_hi <= |w_d_goal[31:8];
            r_left_lo <= w_d_goal[7:0];
        end
    end

    // execute stage helpers
    logic signed [9:0] w_acc_sum;
    logic signed [9:0] w_goal10;
    logic              w_ainc_pos;
    logic [7:0]        w_acc_spd;
    logic              w_s_le_rem;
    logic signed [8:0] w_dec_sub;
    logic              w_exact;
    logic [7:0]        w_dec_spd;
    logic              w_rem_over;
    logic              w_spd_over;

    always_comb begin
        w_acc_sum  = signed'({2'b00, r_speed}) + signed'({r_acc_step[8], r_acc_step});
        w_goal10   = signed'({2'b00, r_goal_spd});
        w_ainc_pos = !r_acc_step[8] && (r_acc_step != '0);
        if (w_ainc_pos) begin
            w_acc_spd = (w_acc_sum > w_goal10) ? r_goal_spd : w_acc_sum[7:0];
        end else begin
            w_acc_spd = (w_acc_sum < w_goal10) ? r_goal_spd : w_acc_sum[7:0];
        end
        w_s_le_rem = signed'({2'b00, r_speed}) <= signed'({r_rem[8], r_rem});
        w_dec_sub  = signed'({1'b0, r_speed}) - signed'({1'b0, r_dec_step});
        w_exact    = (w_dec_sub == '0) && !r_left_hi && (r_left_lo == r_dec_step);
        // speed driven below zero restarts at one
        w_dec_spd  = w_dec_sub[8] ? 8'd1 : w_dec_sub[7:0];
        w_rem_over = !r_left_hi && (r_left_lo < r_rem[7:0]);
        w_spd_over = !r_left_hi && (r_left_lo < w_dec_spd);
    end

    // next state for the item
    logic [31:0] n_cur;
    logic [31:0] n_goal;
    logic [31:0] n_acc_end;
    logic [31:0] n_dec_start;
    logic [7:0]  n_speed;
    logic [7:0]  n_goal_spd;
    logic [8:0]  n_acc_step;
    logic [7:0]  n_dec_step;
    logic [8:0]  n_rem;
    logic        n_fwd;
    logic [1:0]  n_phase;
    logic        n_enable;
    logic [7:0]  n_steps;
    logic        n_set_steps;
    logic        n_move;
    logic [7:0]  n_amt;
    logic        n_run;
    logic        n_pw;
    logic [7:0]  n_pbyte;
    logic        n_stopreq;

    always_comb begin
        n_cur       = r_cur;
        n_goal      = r_goal;
        n_acc_end   = r_acc_end;
        n_dec_start = r_dec_start;
        n_speed     = r_speed;
        n_goal_spd  = r_goal_spd;
        n_acc_step  = r_acc_step;
        n_dec_step  = r_dec_step;
        n_rem       = r_rem;
        n_fwd       = r_fwd;
        n_phase     = r_phase;
        n_enable    = r_enable;
        n_steps     = r_steps;
        n_set_steps = 1'b0;
        n_move      = 1'b0;
        n_amt       = '0;
        n_run       = 1'b0;
        n_pw        = 1'b0;
        n_pbyte     = '0;
        n_stopreq   = 1'b0;
        case (r_op)
            OP_TICK: begin
                if (!r_at_goal) begin
                    n_run = 1'b1;
                    if (r_a_acc) begin
                        // accelerate, clamped to cruise speed
                        n_speed     = w_acc_spd;
                        n_move      = 1'b1;
                        n_amt       = w_acc_spd;
                        n_steps     = w_acc_spd;
                        n_set_steps = 1'b1;
                    end else if (r_a_dec) begin
                        // cruise: no driver update
                        n_move = 1'b1;
                        n_amt  = r_speed;
                        n_run  = 1'b0;
                    end else if (r_a_goal) begin
                        if (w_s_le_rem) begin
                            // final short move
                            if (w_rem_over) begin
                                n_cur   = r_goal;
                                n_steps = r_left_lo;
                            end else begin
                                n_move  = 1'b1;
                                n_amt   = r_rem[7:0];
                                n_steps = r_rem[7:0];
                            end
                            n_set_steps = 1'b1;
                            n_rem       = '1;
                        end else if (w_exact) begin
                            // lands exactly with the last decrement
                            n_speed     = '0;
                            n_cur       = r_goal;
                            n_steps     = r_dec_step;
                            n_set_steps = 1'b1;
                            n_run       = 1'b0;
                        end else begin
                            if (w_spd_over) begin
                                n_speed = r_left_lo;
                                n_cur   = r_goal;
                                n_steps = r_left_lo;
                            end else begin
                                n_speed = w_dec_spd;
                                n_move  = 1'b1;
                                n_amt   = w_dec_spd;
                                n_steps = w_dec_spd;
                            end
                            n_set_steps = 1'b1;
                        end
                    end else begin
                        // beyond the target: halt in place
                        n_speed     = '0;
                        n_steps     = '0;
                        n_set_steps = 1'b1;
                    end
                end else begin
                    case (r_phase)
                        PH_ARMED: begin
                            n_phase     = PH_STOPPED;
                            n_speed     = '0;
                            n_steps     = '0;
                            n_set_steps = 1'b1;
                            if (r_cut_off) begin
                                n_enable = 1'b0;
                            end
                            n_pw    = 1'b1;
                            n_pbyte = pulse_byte(r_stop_pwr);
                            n_run   = 1'b1;
                        end
                        PH_STOPPED: begin
                            n_phase   = PH_DONE;
                            n_stopreq = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            OP_PLAN: begin
                n_goal      = r_in_target;
                n_acc_end   = r_in_accend;
                n_dec_start = r_in_decst;
                n_goal_spd  = r_in_cruise;
                n_acc_step  = r_in_ainc;
                n_dec_step  = r_in_ddec;
                n_rem       = r_in_frem;
                n_fwd       = r_in_fwd;
                n_phase     = PH_ARMED;
                n_enable    = 1'b1;
                n_pw        = 1'b1;
                n_pbyte     = pulse_byte(r_run_pwr);
            end
            OP_SET: begin
                n_cur = r_in_newpos;
            end
            default: ;
        endcase
        // one shared position adder, wraps in 32 bits
        if (n_move) begin
            n_cur = r_fwd ? (r_cur + {24'd0, n_amt}) : (r_cur - {24'd0, n_amt});
        end
    end

    // divider for the step period
    logic [15:0] w_quot;
    logic        w_div_done;

    tsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_frame),
        .i_divisor  (r_steps),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_goal      <= '0;
            r_acc_end   <= '0;
            r_dec_start <= '0;
            r_speed     <= '0;
            r_goal_spd  <= '0;
            r_acc_step  <= '0;
            r_dec_step  <= '0;
            r_rem       <= '0;
            r_fwd       <= 1'b0;
            r_phase     <= PH_ARMED;
            r_enable    <= 1'b0;
            r_steps     <= '0;
            r_period    <= '0;
            r_need_div  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_cur       <= n_cur;
                r_goal      <= n_goal;
                r_acc_end   <= n_acc_end;
                r_dec_start <= n_dec_start;
                r_speed     <= n_speed;
                r_goal_spd  <= n_goal_spd;
                r_acc_step  <= n_acc_step;
                r_dec_step  <= n_dec_step;
                r_rem       <= n_rem;
                r_fwd       <= n_fwd;
                r_phase     <= n_phase;
                r_enable    <= n_enable;
                r_need_div  <= n_set_steps && (n_steps != '0);
                if (n_set_steps) begin
                    r_steps <= n_steps;
                    if (n_steps == '0) begin
                        r_period <= '0;
                    end
                end
            end
            if (w_div_done) begin
                r_period <= w_quot;
            end
        end
    end

    // item flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_run     <= n_run;
            r_pw      <= n_pw;
            r_pbyte   <= n_pbyte;
            r_stopreq <= n_stopreq;
        end
    end

    // output register
    logic        r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [15:0] w_run_word;
    logic [OUT_TDATA_W-1:0] w_out_word;

    assign w_run_word = {2'b00, r_mode, 1'b0, r_enable, 1'b0, r_fwd ^ r_reverse, r_steps};
    assign w_out_word = {4'd0, r_cur, (r_cur != r_goal), r_stopreq,
                         r_pbyte, r_pbyte, r_pw, r_period, w_run_word, r_run};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= w_out_word;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_sts.need_div  = r_need_div;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

### dv/tb_trapezoid_step_profile_tick.sv
// Self-checking bench for trapezoid_step_profile_tick: plan, set and frame-tick words
// are checked against a cycle-free profile predictor kept alongside the stream.
// Depends on tsp_pkg and the trapezoid_step_profile_tick RTL.
`timescale 1ns / 1ps

module tb_trapezoid_step_profile_tick;
    import tsp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;   // no-op code, must leave state untouched
    localparam int ITEM_GOAL    = 1650;
    localparam int STALL_LIMIT  = 2000;       // cycles with no word moving on either side
    localparam int DRAIN_PAUSE  = 30;         // covers the divider path latency
    localparam int MOVE_TICKS   = 80;

    // One input word, fields split out
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] newpos;
        logic        fwd;
        logic [8:0]  frem;
        logic [7:0]  ddec;
        logic [8:0]  ainc;
        logic [7:0]  cruise;
        logic [31:0] decst;
        logic [31:0] accend;
        logic [31:0] target;
    } t_item;

    // One driver update word, fields split out
    typedef struct packed {
        logic        run_upd;
        logic [15:0] run_word;
        logic [15:0] period_word;
        logic        pwr_upd;
        logic [15:0] pulse_word;
        logic        stop_req;
        logic        running;
        logic [31:0] pos_now;
    } t_result;

    typedef struct packed {
        logic [15:0] frame_period;
        logic [6:0]  run_pct;
        logic [6:0]  stop_pct;
        logic        cut_off;
        logic        reverse;
        logic [1:0]  ustep;
    } t_setup;

    // DUT connections
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = OP_TICK;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = REG_FRAME_PERIOD;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    trapezoid_step_profile_tick u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the profile state and registers
    t_setup      setup_q = '{RST_FRAME_PERIOD, RST_RUN_POWER, RST_STOP_POWER, 1'b0, 1'b0, 2'd0};
    logic [31:0] pos_q = '0;
    logic [31:0] goal_q = '0;
    logic [31:0] accel_limit_q = '0;
    logic [31:0] decel_from_q = '0;
    int          speed_q = 0;
    int          cruise_q = 0;
    int          ainc_q = 0;
    int          ddec_q = 0;
    int          tail_q = 0;
    logic        dir_fwd_q = 1'b0;
    logic [1:0]  stop_ph_q = PH_ARMED;
    logic        enable_q = 1'b0;
    logic [7:0]  steps_q = '0;
    logic [15:0] period_q = '0;

    t_result     expected_words[$];
    t_result     last_word;
    int          items_sent = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          ready_hold;
    bit          in_steady = 1'b0;
    bit          out_steady = 1'b0;

    // Signed distance from a to b along the current direction of travel
    function automatic longint dist_to(logic [31:0] a, logic [31:0] b);
        longint d;
        d = longint'($signed(b)) - longint'($signed(a));
        return dir_fwd_q ? d : -d;
    endfunction

    function automatic void move_by(int v);
        pos_q = dir_fwd_q ? pos_q + 32'(v) : pos_q - 32'(v);
    endfunction

    function automatic void load_steps(int v);
        steps_q  = v[7:0];
        period_q = (v <= 0) ? 16'd0 : 16'(int'(setup_q.frame_period) / v);
    endfunction

    // Peak pulse byte 64*percent/100, percent capped at 100, in both halves
    function automatic logic [15:0] drive_pulse(logic [6:0] pct);
        int p;
        p = (pct > 7'd100) ? 100 : int'(pct);
        p = 64 * p / 100;
        return {p[7:0], p[7:0]};
    endfunction

    // Advance the predictor by one word and return the driver update it causes
    function automatic t_result predict_word(t_item it);
        t_result r;
        longint  left;
        int      mv;
        r = '0;
        case (it.op)
            OP_TICK: begin
                if (pos_q != goal_q) begin
                    r.run_upd = 1'b1;
                    if (dist_to(pos_q, accel_limit_q) > 0) begin
                        // accelerate, clamped at cruise from either side
                        speed_q += ainc_q;
                        if (ainc_q > 0) begin
                            if (speed_q > cruise_q) speed_q = cruise_q;
                        end else if (speed_q < cruise_q) begin
                            speed_q = cruise_q;
                        end
                        move_by(speed_q);
                        load_steps(speed_q);
                    end else if (dist_to(pos_q, decel_from_q) > 0) begin
                        // cruise: same speed, no driver write
                        move_by(speed_q);
                        r.run_upd = 1'b0;
                    end else if (dist_to(pos_q, goal_q) > 0) begin
                        left = dist_to(pos_q, goal_q);
                        if (speed_q <= tail_q) begin
                            // one-shot remainder move, clamped onto the target
                            mv = tail_q;
                            if (longint'(mv) > left) begin
                                mv = int'(left);
                                pos_q = goal_q;
                            end else begin
                                move_by(mv);
                            end
                            load_steps(mv);
                            tail_q = -1;
                        end else begin
                            speed_q -= ddec_q;
                            if (speed_q == 0 && left == longint'(ddec_q)) begin
                                // lands exactly, steps shown but no run write
                                pos_q = goal_q;
                                load_steps(ddec_q);
                                r.run_upd = 1'b0;
                            end else begin
                                if (speed_q < 0) speed_q = 1;
                                if (longint'(speed_q) > left) begin
                                    speed_q = int'(left);
                                    pos_q = goal_q;
                                end else begin
                                    move_by(speed_q);
                                end
                                load_steps(speed_q);
                            end
                        end
                    end else begin
                        // overshot the target
                        speed_q = 0;
                        load_steps(0);
                    end
                end else if (stop_ph_q == PH_ARMED) begin
                    stop_ph_q = PH_STOPPED;
                    speed_q = 0;
                    load_steps(0);
                    if (setup_q.cut_off) enable_q = 1'b0;
                    r.run_upd    = 1'b1;
                    r.pwr_upd    = 1'b1;
                    r.pulse_word = drive_pulse(setup_q.stop_pct);
                end else if (stop_ph_q == PH_STOPPED) begin
                    stop_ph_q = PH_DONE;
                    r.stop_req = 1'b1;
                end
            end
            OP_PLAN: begin
                goal_q        = it.target;
                accel_limit_q = it.accend;
                decel_from_q  = it.decst;
                cruise_q      = int'(it.cruise);
                ainc_q        = int'($signed(it.ainc));
                ddec_q        = int'(it.ddec);
                tail_q        = int'($signed(it.frem));
                dir_fwd_q     = it.fwd;
                stop_ph_q     = PH_ARMED;
                enable_q      = 1'b1;
                r.pwr_upd     = 1'b1;
                r.pulse_word  = drive_pulse(setup_q.run_pct);
            end
            OP_SET: pos_q = it.newpos;
            default: ;
        endcase
        r.run_word    = {2'b00, setup_q.ustep, 1'b0, enable_q, 1'b0,
                         dir_fwd_q ^ setup_q.reverse, steps_q};
        r.period_word = period_q;
        r.running     = (pos_q != goal_q);
        r.pos_now     = pos_q;
        return r;
    endfunction

    // Random word, every field within its range
    function automatic t_item any_item();
        t_item it;
        it.op     = 2'($urandom_range(0, 3));
        it.target = $urandom();
        it.accend = $urandom();
        it.decst  = $urandom();
        it.cruise = 8'($urandom_range(0, 255));
        it.ainc   = 9'($urandom_range(0, 510) - 255);
        it.ddec   = 8'($urandom_range(0, 255));
        it.frem   = 9'($urandom_range(0, 256) - 1);
        it.fwd    = 1'($urandom_range(0, 1));
        it.newpos = $urandom();
        return it;
    endfunction

    function automatic t_item mk_tick();
        t_item it;
        it = any_item();
        it.op = OP_TICK;
        return it;
    endfunction

    function automatic t_item mk_set(logic [31:0] p);
        t_item it;
        it = any_item();
        it.op = OP_SET;
        it.newpos = p;
        return it;
    endfunction

    function automatic t_item mk_plan(logic [31:0] tgt, logic [31:0] ae, logic [31:0] ds,
                                      int cruise, int ainc, int ddec, int frem, logic fwd);
        t_item it;
        it = any_item();
        it.op     = OP_PLAN;
        it.target = tgt;
        it.accend = ae;
        it.decst  = ds;
        it.cruise = 8'(cruise);
        it.ainc   = 9'(ainc);
        it.ddec   = 8'(ddec);
        it.frem   = 9'(frem);
        it.fwd    = fwd;
        return it;
    endfunction

    function automatic logic [31:0] along(logic [31:0] b, logic fwd, int n);
        return fwd ? b + 32'(n) : b - 32'(n);
    endfunction

    // Present one word after a random gap; predict it at the accepting edge.
    // tvalid stays high on return so back-to-back words need no low cycle.
    task automatic send_word(input t_item it);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {5'b0, it.newpos, it.fwd, it.frem, it.ddec, it.ainc, it.cruise,
                          it.decst, it.accend, it.target};
        s_axis_tuser  <= it.op;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        last_word = predict_word(it);
        expected_words.push_back(last_word);
        items_sent++;
    endtask

    // Stop sending and wait until every update word has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Write every register; only called with the block idle
    task automatic apply_setup(input t_setup s);
        put_reg(REG_FRAME_PERIOD, s.frame_period);
        put_reg(REG_RUN_POWER, 16'(s.run_pct));
        put_reg(REG_STOP_POWER, 16'(s.stop_pct));
        put_reg(REG_CUT_OFF, 16'(s.cut_off));
        put_reg(REG_REVERSE, 16'(s.reverse));
        put_reg(REG_USTEP_MODE, 16'(s.ustep));
        i_cfg_we <= 1'b0;
        setup_q = s;
    endtask

    // A move with random content, mostly well-formed, ticked until the stop request or MOVE_TICKS ticks
    task automatic run_move();
        t_item       it;
        logic [31:0] base;
        logic        fwd;
        int          spd, a_len, c_len, d_len, ainc;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0:       base = 32'h7FFF_FFFF - $urandom_range(0, 2000);
                1:       base = 32'h8000_0000 + $urandom_range(0, 2000);
                default: base = $urandom();
            endcase
            send_word(mk_set(base));
        end
        base  = pos_q;
        fwd   = 1'($urandom_range(0, 1));
        spd   = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255);
        a_len = $urandom_range(0, 3 * spd + 3);
        c_len = $urandom_range(0, 6 * spd + 6);
        d_len = $urandom_range(0, 2 * spd + 30);
        ainc  = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 255)
                                            : $urandom_range(0, 510) - 255;
        it = mk_plan(along(base, fwd, a_len + c_len + d_len), along(base, fwd, a_len),
                     along(base, fwd, a_len + c_len), spd, ainc, $urandom_range(0, 255),
                     $urandom_range(0, 256) - 1, fwd);
        // occasionally a broken plan with stray breakpoints
        if ($urandom_range(0, 7) == 0) begin
            it.accend = $urandom();
            it.decst  = $urandom();
        end
        send_word(it);
        for (int n = 0; n < MOVE_TICKS; n++) begin
            if ($urandom_range(0, 15) == 0) send_word(any_item());
            send_word(mk_tick());
            if (last_word.stop_req) break;
        end
        repeat ($urandom_range(0, 2)) send_word(mk_tick());
    endtask

    // At rest after reset: stop, stop request, then nothing more
    task automatic test_rest_ticks();
        repeat (3) send_word(mk_tick());
    endtask

    // Hand-built corner cases with the reset register values
    task automatic test_directed_cases();
        t_item it;
        it = '1;
        it.op = OP_UNUSED;
        send_word(it);
        // build speed 10, then an exact landing on the last decrement
        send_word(mk_plan(32'd1000, 32'd1000, 32'd1000, 10, 10, 0, -1, 1'b1));
        send_word(mk_tick());
        send_word(mk_set(32'd0));
        send_word(mk_plan(32'd10, 32'd0, 32'd0, 0, 0, 10, -1, 1'b1));
        send_word(mk_tick());
        send_word(mk_tick());
        // accelerate clamped to 5, then a decrement below zero gives speed 1
        send_word(mk_plan(32'd5000, 32'd5000, 32'd5000, 5, 255, 0, -1, 1'b1));
        send_word(mk_tick());
        send_word(mk_plan(32'd100, 32'd0, 32'd0, 0, -255, 255, -1, 1'b1));
        send_word(mk_tick());
        // speed reaches zero away from the target
        send_word(mk_plan(32'd100, 32'd0, 32'd0, 0, -255, 1, -1, 1'b1));
        send_word(mk_tick());
        // remainder move longer than what is left
        send_word(mk_plan(32'd100, 32'd0, 32'd0, 255, 255, 255, 255, 1'b1));
        send_word(mk_tick());
        // position wraps forward past the top, then backward past the bottom
        send_word(mk_set(32'h7FFF_FFF0));
        send_word(mk_plan(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 255, 255, 255, 255,
                          1'b1));
        send_word(mk_tick());
        send_word(mk_plan(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 255, 255, 255, 255,
                          1'b0));
        send_word(mk_tick());
        // target behind the position: speed drops to zero
        send_word(mk_plan(32'h8000_0000, 32'd0, 32'd0, 255, -255, 0, -1, 1'b1));
        send_word(mk_tick());
        send_word(mk_set(32'h8000_0000));
    endtask

    // Fixed register settings, extremes included, each with a few moves
    task automatic test_register_sweep();
        t_setup sweep [4];
        sweep = '{'{16'd0,     7'd0,   7'd0,   1'b0, 1'b0, 2'd0},
                  '{16'd65535, 7'd100, 7'd100, 1'b1, 1'b1, 2'd3},
                  '{16'd1,     7'd37,  7'd7,   1'b1, 1'b0, 2'd2},
                  '{16'd13333, 7'd100, 7'd60,  1'b0, 1'b1, 2'd1}};
        foreach (sweep[k]) begin
            settle();
            apply_setup(sweep[k]);
            out_steady = (k == 1);
            repeat (4) run_move();
        end
        out_steady = 1'b0;
    endtask

    // Random register settings and idling, mostly well-formed moves plus noise
    task automatic test_random_moves();
        t_setup s;
        int     phase_end;
        while (items_sent < ITEM_GOAL) begin
            settle();
            case ($urandom_range(0, 3))
                0:       s.frame_period = 16'd0;
                1:       s.frame_period = 16'hFFFF;
                default: s.frame_period = 16'($urandom());
            endcase
            s.run_pct  = 7'($urandom_range(0, 100));
            s.stop_pct = 7'($urandom_range(0, 100));
            s.cut_off  = 1'($urandom_range(0, 1));
            s.reverse  = 1'($urandom_range(0, 1));
            s.ustep    = 2'($urandom_range(0, 3));
            apply_setup(s);
            in_steady  = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
            phase_end  = items_sent + 150;
            while (items_sent < phase_end && items_sent < ITEM_GOAL) begin
                if ($urandom_range(0, 9) == 0) send_word(any_item());
                else run_move();
            end
        end
    endtask

    // Sink side: random stall before taking each word
    always begin
        ready_hold = out_steady ? 0 : $urandom_range(0, 19);
        if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            repeat (ready_hold) @(posedge i_clk);
        end
        m_axis_tready <= 1'b1;
        do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
    end

    // Compare each accepted update word with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.run_upd     = m_axis_tdata[0];
            got.run_word    = m_axis_tdata[16:1];
            got.period_word = m_axis_tdata[32:17];
            got.pwr_upd     = m_axis_tdata[33];
            got.pulse_word  = m_axis_tdata[49:34];
            got.stop_req    = m_axis_tdata[50];
            got.running     = m_axis_tdata[51];
            got.pos_now     = m_axis_tdata[83:52];
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: update word %h with nothing pending", $time, m_axis_tdata);
            end else begin
                want = expected_words.pop_front();
                if (got.run_upd !== want.run_upd || got.run_word !== want.run_word ||
                    got.period_word !== want.period_word || got.pwr_upd !== want.pwr_upd ||
                    got.pulse_word !== want.pulse_word || got.stop_req !== want.stop_req ||
                    got.running !== want.running || got.pos_now !== want.pos_now) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        // run_upd run_word period pwr_upd pulse stop_req running pos
                        $display("%0t: mismatch exp %b %h %h %b %h %b %b %h", $time,
                                 want.run_upd, want.run_word, want.period_word, want.pwr_upd,
                                 want.pulse_word, want.stop_req, want.running, want.pos_now);
                        $display("%0t:          got %b %h %h %b %h %b %b %h", $time,
                                 got.run_upd, got.run_word, got.period_word, got.pwr_upd,
                                 got.pulse_word, got.stop_req, got.running, got.pos_now);
                    end
                end
            end
        end
    end

    // Watchdog: no word moving on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_trapezoid_step_profile_tick: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_rest_ticks();
        test_directed_cases();
        test_register_sweep();
        test_random_moves();
        settle();
        if (fail_count == 0) begin
            $display("tb_trapezoid_step_profile_tick: PASS");
        end else begin
            $display("tb_trapezoid_step_profile_tick: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
sv/tsp_pkg.sv
sv/tsp_div.sv
sv/tsp_ctrl.sv
sv/tsp_dp.sv
sv/trapezoid_step_profile_tick.sv
dv/tb_trapezoid_step_profile_tick.sv
